>>> rtl/core/pdir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdir_pkg
// Shared types, register indexes, status codes and defaults for the
// pulse-distance IR frame decoder.
// ----------------------------------------------------------------------------
package pdir_pkg;

  localparam int DUR_W     = 15;
  localparam int CODE_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int SYM_IDX_W = 7;
  localparam int MARGIN_W  = 12;

  localparam int FRAME_SYMBOLS_DEF = 34;
  localparam int MAX_CAPTURE_DEF   = 64;
  localparam int TIME_MARGIN_DEF   = 300;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER_MARK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SPACE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MARK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MARK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FOOTER_MARK  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FOOTER_SPACE = 3'd7;

  localparam logic [DUR_W-1:0] RST_HEADER_MARK  = 15'd9000;
  localparam logic [DUR_W-1:0] RST_HEADER_SPACE = 15'd4500;
  localparam logic [DUR_W-1:0] RST_ONE_MARK     = 15'd560;
  localparam logic [DUR_W-1:0] RST_ONE_SPACE    = 15'd1690;
  localparam logic [DUR_W-1:0] RST_ZERO_MARK    = 15'd560;
  localparam logic [DUR_W-1:0] RST_ZERO_SPACE   = 15'd560;
  localparam logic [DUR_W-1:0] RST_FOOTER_MARK  = 15'd560;
  localparam logic [DUR_W-1:0] RST_FOOTER_SPACE = 15'd0;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_SHORT    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_MISMATCH = 2'd2;

  localparam logic [CODE_W-1:0] CODE_MSB = 32'h8000_0000;

  // Classified symbol handed from the front to the back.
  typedef struct packed {
    logic hdr_ok;
    logic one_ok;
    logic zero_ok;
    logic ftr_ok;
    logic last;
  } pdir_token_t;

endpackage : pdir_pkg
`default_nettype wire

>>> rtl/core/pdir_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdir_front
// Holds the timing registers and classifies each incoming symbol against the
// header, one, zero and footer windows.
// ----------------------------------------------------------------------------
module pdir_front #(
  parameter int TIME_MARGIN = pdir_pkg::TIME_MARGIN_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [0] mark_level, [15:1] mark_duration, [16] space_level, [31:17] space_duration
  input  wire logic [31:0]                     in_tdata,
  input  wire logic                            in_tlast,
  input  wire logic                            cfg_we,
  input  wire logic [pdir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pdir_pkg::DUR_W-1:0]      cfg_wdata,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output pdir_pkg::pdir_token_t                q_token
);
  import pdir_pkg::*;

  localparam logic [DUR_W:0] MARGIN = (DUR_W+1)'(TIME_MARGIN);

  logic [DUR_W-1:0] hdr_mark_r, hdr_space_r, one_mark_r, one_space_r;
  logic [DUR_W-1:0] zero_mark_r, zero_space_r, ftr_mark_r, ftr_space_r;
  logic             mark_lvl, space_lvl, lvl_ok;
  logic [DUR_W-1:0] mark_dur, space_dur;

  function automatic logic in_window(input logic [DUR_W-1:0] d,
                                     input logic [DUR_W-1:0] e);
    logic [DUR_W:0] dx;
    logic [DUR_W:0] ex;
    dx = {1'b0, d};
    ex = {1'b0, e};
    return (dx < ex + MARGIN) && (dx + MARGIN > ex);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_mark_r   <= RST_HEADER_MARK;
      hdr_space_r  <= RST_HEADER_SPACE;
      one_mark_r   <= RST_ONE_MARK;
      one_space_r  <= RST_ONE_SPACE;
      zero_mark_r  <= RST_ZERO_MARK;
      zero_space_r <= RST_ZERO_SPACE;
      ftr_mark_r   <= RST_FOOTER_MARK;
      ftr_space_r  <= RST_FOOTER_SPACE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER_MARK:  hdr_mark_r   <= cfg_wdata;
        REG_HEADER_SPACE: hdr_space_r  <= cfg_wdata;
        REG_ONE_MARK:     one_mark_r   <= cfg_wdata;
        REG_ONE_SPACE:    one_space_r  <= cfg_wdata;
        REG_ZERO_MARK:    zero_mark_r  <= cfg_wdata;
        REG_ZERO_SPACE:   zero_space_r <= cfg_wdata;
        REG_FOOTER_MARK:  ftr_mark_r   <= cfg_wdata;
        REG_FOOTER_SPACE: ftr_space_r  <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  assign mark_lvl  = in_tdata[0];
  assign mark_dur  = in_tdata[15:1];
  assign space_lvl = in_tdata[16];
  assign space_dur = in_tdata[31:17];
  assign lvl_ok    = !mark_lvl && space_lvl;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_token.hdr_ok  = lvl_ok && in_window(mark_dur, hdr_mark_r)
                             && in_window(space_dur, hdr_space_r);
    q_token.one_ok  = lvl_ok && in_window(mark_dur, one_mark_r)
                             && in_window(space_dur, one_space_r);
    q_token.zero_ok = lvl_ok && in_window(mark_dur, zero_mark_r)
                             && in_window(space_dur, zero_space_r);
    q_token.ftr_ok  = lvl_ok && in_window(mark_dur, ftr_mark_r)
                             && in_window(space_dur, ftr_space_r);
    q_token.last    = in_tlast;
  end

endmodule : pdir_front
`default_nettype wire

>>> rtl/core/pdir_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdir_queue
// Two-entry queue of classified symbols between the front and the back.
// ----------------------------------------------------------------------------
module pdir_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire pdir_pkg::pdir_token_t push_token,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       empty,
  output pdir_pkg::pdir_token_t      head_token
);
  import pdir_pkg::*;

  pdir_token_t mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        do_push, do_pop;

  assign full       = (count_r == 2'd2);
  assign empty      = (count_r == 2'd0);
  assign do_push    = push && !full;
  assign do_pop     = pop && !empty;
  assign head_token = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_token;
    end
  end

endmodule : pdir_queue
`default_nettype wire

>>> rtl/core/pdir_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdir_back
// Frame sequencer: tracks the symbol position, assembles the code and
// registers one result per capture, or each time MAX_CAPTURE symbols gather.
// ----------------------------------------------------------------------------
module pdir_back #(
  parameter int FRAME_SYMBOLS = pdir_pkg::FRAME_SYMBOLS_DEF,
  parameter int MAX_CAPTURE   = pdir_pkg::MAX_CAPTURE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_empty,
  input  wire pdir_pkg::pdir_token_t          q_head,
  output logic                                q_pop,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [31:0] frame_code
  output logic [pdir_pkg::CODE_W-1:0]         out_tdata,
  // [1:0] frame_status
  output logic [pdir_pkg::STATUS_W-1:0]       out_tuser
);
  import pdir_pkg::*;

  localparam logic [SYM_IDX_W-1:0] FS      = SYM_IDX_W'(FRAME_SYMBOLS);
  localparam logic [SYM_IDX_W-1:0] FS_LAST = SYM_IDX_W'(FRAME_SYMBOLS - 1);
  localparam logic [SYM_IDX_W-1:0] MAXCAP  = SYM_IDX_W'(MAX_CAPTURE);
  localparam logic [SYM_IDX_W-1:0] IDX_SAT = {SYM_IDX_W{1'b1}};

  logic [SYM_IDX_W-1:0] idx_r, idx_nxt, bit_pos, idx_inc;
  logic [CODE_W-1:0]    acc_r, acc_nxt, acc_upd;
  logic                 mis_r, mis_nxt, mis_upd;
  logic                 out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]    out_code_r, out_code_nxt;
  logic [STATUS_W-1:0]  out_stat_r, out_stat_nxt;
  logic                 slot_free, emit;

  assign slot_free  = !out_valid_r || out_tready;
  assign q_pop      = !q_empty && slot_free;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_code_r;
  assign out_tuser  = out_stat_r;
  assign bit_pos    = idx_r - SYM_IDX_W'(1);
  assign idx_inc    = (idx_r == IDX_SAT) ? IDX_SAT : idx_r + SYM_IDX_W'(1);
  assign emit       = q_head.last || (idx_inc >= MAXCAP);

  always_comb begin
    acc_upd = acc_r;
    mis_upd = mis_r;
    if (!mis_r && idx_r < FS) begin
      priority if (idx_r == '0) begin
        mis_upd = !q_head.hdr_ok;
      end else if (idx_r == FS_LAST) begin
        mis_upd = !q_head.ftr_ok;
      end else if (q_head.one_ok) begin
        if (bit_pos < SYM_IDX_W'(CODE_W)) begin
          acc_upd = acc_r | (CODE_MSB >> bit_pos[4:0]);
        end
      end else begin
        mis_upd = !q_head.zero_ok;
      end
    end
  end

  always_comb begin
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    mis_nxt       = mis_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_code_nxt  = out_code_r;
    out_stat_nxt  = out_stat_r;
    if (q_pop) begin
      if (emit) begin
        idx_nxt       = '0;
        acc_nxt       = '0;
        mis_nxt       = 1'b0;
        out_valid_nxt = 1'b1;
        priority if (idx_inc < FS) begin
          out_code_nxt = '0;
          out_stat_nxt = STAT_SHORT;
        end else if (mis_upd) begin
          out_code_nxt = '0;
          out_stat_nxt = STAT_MISMATCH;
        end else begin
          out_code_nxt = acc_upd;
          out_stat_nxt = STAT_OK;
        end
      end else begin
        idx_nxt = idx_inc;
        acc_nxt = acc_upd;
        mis_nxt = mis_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      acc_r       <= '0;
      mis_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      acc_r       <= acc_nxt;
      mis_r       <= mis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_code_r <= out_code_nxt;
    out_stat_r <= out_stat_nxt;
  end

endmodule : pdir_back
`default_nettype wire

>>> rtl/core/pulse_distance_ir_frame_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_distance_ir_frame_decoder_top
// Decodes captured pulse-distance IR symbols into 32-bit frame codes.
// ----------------------------------------------------------------------------
// Each input transfer carries one symbol; tlast marks the final symbol of a
// capture, and one result transfer with the code and a status follows every
// capture, and also each run of MAX_CAPTURE symbols without tlast. The block
// takes one symbol per clock cycle while the queue is not full: a classifier
// compares the symbol against all four timing windows in the cycle of the
// transfer, a two-entry queue holds the classified symbols, and the frame
// sequencer retires one symbol per cycle while its output register is free
// or being drained. The result is registered once the last symbol leaves the queue.
// ----------------------------------------------------------------------------
module pulse_distance_ir_frame_decoder_top #(
  parameter int FRAME_SYMBOLS = pdir_pkg::FRAME_SYMBOLS_DEF,
  parameter int MAX_CAPTURE   = pdir_pkg::MAX_CAPTURE_DEF,
  parameter int TIME_MARGIN   = pdir_pkg::TIME_MARGIN_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [0] mark_level, [15:1] mark_duration, [16] space_level, [31:17] space_duration
  input  wire logic [31:0]                    in_tdata,
  input  wire logic                           in_tlast,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [31:0] frame_code
  output logic [pdir_pkg::CODE_W-1:0]         out_tdata,
  // [1:0] frame_status
  output logic [pdir_pkg::STATUS_W-1:0]       out_tuser,
  input  wire logic                           cfg_we,
  input  wire logic [pdir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pdir_pkg::DUR_W-1:0]     cfg_wdata
);
  import pdir_pkg::*;

  pdir_token_t push_token, head_token;
  logic        q_push, q_full, q_pop, q_empty;

  pdir_front #(
    .TIME_MARGIN (TIME_MARGIN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_token   (push_token)
  );

  pdir_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_token (push_token),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head_token (head_token)
  );

  pdir_back #(
    .FRAME_SYMBOLS (FRAME_SYMBOLS),
    .MAX_CAPTURE   (MAX_CAPTURE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (head_token),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule : pulse_distance_ir_frame_decoder_top
`default_nettype wire
